// ----- rtl/core/sma_pkg.sv -----
// Shared constants and types of the smoothed moving average block.
// Used by the divider, the top level and the checker; no dependencies.
package sma_pkg;

	// Width of the period register and of every period-sized counter.
	localparam int P_W = 11;

	// Largest value the period register can hold.
	localparam int PERIOD_REG_MAX = (1 << P_W) - 1;

	// Reset value of the period register.
	localparam logic [P_W-1:0] PERIOD_RESET = P_W'(30);

	// Default parameter values of the top level.
	localparam int PERIOD_MAX_DEF   = 1024;
	localparam int SAMPLE_WIDTH_DEF = 32;

	// Status of the serial divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} sma_div_status_t;

endpackage

// ----- rtl/core/sma_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Divides an unsigned dividend by an unsigned period; depends on sma_pkg.
module sma_div #(
	parameter int DIV_W = 42
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DIV_W-1:0]            dividend,
	input  logic [sma_pkg::P_W-1:0]     divisor,
	output logic [DIV_W-1:0]            quotient,
	output sma_pkg::sma_div_status_t    status
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [sma_pkg::P_W:0]   rem_q;
	logic [DIV_W-1:0]        acc_q;
	logic [sma_pkg::P_W-1:0] dsr_q;
	logic [CNT_W-1:0]        cnt_q;

	logic [sma_pkg::P_W:0]   rem_sh;
	logic [sma_pkg::P_W:0]   trial;
	logic                    ge;

	// The remainder stays below the divisor, so its top bit is free for the shift.
	assign rem_sh = {rem_q[sma_pkg::P_W-1:0], acc_q[DIV_W-1]};
	assign trial  = rem_sh - {1'b0, dsr_q};
	assign ge     = rem_sh >= {1'b0, dsr_q};

	assign status.busy = cnt_q != '0;
	assign status.done = cnt_q == CNT_W'(1);
	assign quotient    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			acc_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? trial : rem_sh;
			acc_q <= {acc_q[DIV_W-2:0], ge};
		end
	end

endmodule

// ----- rtl/core/smoothed_moving_average_unit.sv -----
// An item that needs a division runs through the serial divider and ST_FIN before its result
// reaches ST_DONE; an item that yields an invalid result without dividing goes straight to
// ST_DONE. No new input beat is taken until the last result has left ST_DONE for the output
// register; while a result beat is held back by out_ready, the next finished result waits in
// ST_DONE, and that delays the input beat after it as long.
// Reset (arst_n low, asynchronous): the series state clears and period returns to 30.
module smoothed_moving_average_unit #(
	parameter int PERIOD_MAX   = sma_pkg::PERIOD_MAX_DEF,
	parameter int SAMPLE_WIDTH = sma_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel: the period register.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sma_pkg::P_W-1:0]       cfg_data,
	// Input sample channel.
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          series_start,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                          sample_valid,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] average,
	output logic                          average_valid
);

	localparam int P_W   = sma_pkg::P_W;
	localparam int SW    = SAMPLE_WIDTH;
	// The running sum holds up to PERIOD_MAX samples, so it needs log2 extra bits.
	localparam int SUM_W = SW + $clog2(PERIOD_MAX);
	localparam int DIV_W = SUM_W;
	// The register cannot exceed its own width, so the clip only matters below that.
	localparam int PCLIP_I = (PERIOD_MAX > sma_pkg::PERIOD_REG_MAX) ?
		sma_pkg::PERIOD_REG_MAX : PERIOD_MAX;
	localparam logic [P_W-1:0] PCLIP = PCLIP_I[P_W-1:0];

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [P_W-1:0]        period_q;
	logic [P_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SW-1:0]  prev_q;
	logic                  broken_q;
	logic                  seed_q;
	logic                  neg_q;
	logic signed [SW-1:0]  res_avg_q;
	logic                  res_ok_q;

	// Effective period: zero acts as one and values above the maximum are clipped.
	logic [P_W-1:0]        p_eff;
	logic                  in_beat;
	logic [P_W-1:0]        cnt_base;
	logic [P_W-1:0]        cnt_clip;
	logic [P_W-1:0]        cnt_inc;
	logic                  brk;
	logic signed [SUM_W-1:0] sum_base;
	logic signed [SUM_W-1:0] sum_add;
	logic signed [SW-1:0]  prev_base;
	logic signed [SW:0]    diff;
	logic                  filling;
	logic [P_W-1:0]        count_n;
	logic signed [SUM_W-1:0] sum_n;
	logic                  need_div;
	logic                  seed_n;
	logic signed [SUM_W-1:0] num;
	logic [DIV_W-1:0]      dvd;

	logic [DIV_W-1:0]      quo;
	sma_pkg::sma_div_status_t div_st;
	logic [DIV_W-1:0]      q_floor;
	logic signed [SW-1:0]  avg_fin;
	logic                  out_load;

	always_comb begin
		if (period_q == '0) begin
			p_eff = P_W'(1);
		end else if (period_q > PCLIP) begin
			p_eff = PCLIP;
		end else begin
			p_eff = period_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE) && !div_st.busy;
	assign in_beat   = in_valid && in_ready;

	// Series bookkeeping for the item on the input port. A start beat sees cleared
	// state; a count left above a lowered period is pulled back to it.
	always_comb begin
		cnt_base  = series_start ? '0 : count_q;
		cnt_clip  = (cnt_base > p_eff) ? p_eff : cnt_base;
		cnt_inc   = cnt_clip + P_W'(1);
		brk       = (series_start ? 1'b0 : broken_q) | ~sample_valid;
		sum_base  = series_start ? '0 : sum_q;
		prev_base = series_start ? '0 : prev_q;
		sum_add   = sum_base + SUM_W'(sample);
		diff      = (SW+1)'(sample) - (SW+1)'(prev_base);
		filling   = cnt_clip < p_eff;
		if (filling) begin
			// Seeding: sum the sample unless the series is broken, and divide the sum once the window is full.
			count_n  = cnt_inc;
			sum_n    = brk ? sum_base : sum_add;
			need_div = !brk && (cnt_inc == p_eff);
			seed_n   = 1'b1;
			num      = sum_add;
		end else begin
			// Recurrence: previous + floor((sample - previous) / period).
			count_n  = cnt_clip;
			sum_n    = sum_base;
			need_div = !brk;
			seed_n   = 1'b0;
			num      = SUM_W'(diff);
		end
		// For a negative n, floor(n / d) equals the complement of (~n) / d.
		dvd = num[SUM_W-1] ? DIV_W'(~num) : DIV_W'(num);
	end

	sma_div #(
		.DIV_W (DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_beat && need_div),
		.dividend (dvd),
		.divisor  (p_eff),
		.quotient (quo),
		.status   (div_st)
	);

	assign q_floor = neg_q ? ~quo : quo;
	assign avg_fin = seed_q ? q_floor[SW-1:0] : prev_q + q_floor[SW-1:0];

	// The finished result moves into the output register once that register is free.
	assign out_load = (state_q == ST_DONE) && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			period_q      <= sma_pkg::PERIOD_RESET;
			count_q       <= '0;
			sum_q         <= '0;
			prev_q        <= '0;
			broken_q      <= 1'b0;
			seed_q        <= 1'b0;
			neg_q         <= 1'b0;
			res_avg_q     <= '0;
			res_ok_q      <= 1'b0;
			out_valid     <= 1'b0;
			average       <= '0;
			average_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				period_q <= cfg_data;
			end
			if (out_load) begin
				out_valid     <= 1'b1;
				average       <= res_avg_q;
				average_valid <= res_ok_q;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						count_q  <= count_n;
						sum_q    <= sum_n;
						broken_q <= brk;
						prev_q   <= prev_base;
						seed_q   <= seed_n;
						neg_q    <= num[SUM_W-1];
						if (need_div) begin
							state_q <= ST_DIV;
						end else begin
							// No division: the result is invalid and reads as zero.
							res_avg_q <= '0;
							res_ok_q  <= 1'b0;
							state_q   <= ST_DONE;
						end
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					prev_q    <= avg_fin;
					res_avg_q <= avg_fin;
					res_ok_q  <= 1'b1;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					// Hand the result over once the output register is free.
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/sma_checker.sv -----
// Port-level checks of the smoothed moving average block, bound to its top level.
// Depends on smoothed_moving_average_unit for the bind target.
module sma_checker #(
	parameter int SAMPLE_WIDTH = sma_pkg::SAMPLE_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_WIDTH-1:0] average,
	input logic                          average_valid
);

	// An accepted sample keeps the block busy for at least the next cycle.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again right after a beat");

	// An invalid average must read as zero.
	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !average_valid |-> average == '0)
		else $error("invalid average is not zero");

	// A new result only appears after the block has been working on an item.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a sample in progress");

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average) && $stable(average_valid))
		else $error("stalled result changed");

endmodule

bind smoothed_moving_average_unit sma_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_sma_checker (.*);
